// ===== rtl/sff_pkg.sv =====
// Shared types and codes for the flood fill engine.
// Holds the command codes, fixed field widths and the sequencer state type.
// No dependencies.
package sff_pkg;

	// Fixed widths of the word fields
	localparam int CMD_W      = 2;
	localparam int COORD_IN_W = 6;
	localparam int COLOR_IN_W = 4;
	localparam int COUNT_W    = 13;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_POP   = 7'b0001000,
		ST_FETCH = 7'b0010000,
		ST_TEST  = 7'b0100000,
		ST_PUSH  = 7'b1000000
	} state_t;

	// Neighbor push order; the left neighbor goes on last and pops first
	typedef enum logic [1:0] {
		NB_DOWN  = 2'd0,
		NB_UP    = 2'd1,
		NB_RIGHT = 2'd2,
		NB_LEFT  = 2'd3
	} nbr_t;

endpackage

// ===== rtl/stack_flood_fill.sv =====
// Top level of the 4-connected flood fill engine.
// Depends on sff_pkg (codes, state type) and sff_ram (frame store, coordinate stack).
//
// Pixel engine over an internal frame store of FRAME_WIDTH x FRAME_HEIGHT pixels of
// COLOR_BITS each. Every input word (a write, a read, a flood fill or an unused code)
// returns exactly one result word. After reset the frame store is swept to zero, one
// pixel per cycle, over all 2^(clog2(FRAME_WIDTH)+clog2(FRAME_HEIGHT)) addresses
// (4096 at the default size); input stalls during that pass. A write result is
// registered at accept; a read result comes from the frame store's registered read.
// A fill runs from an explicit coordinate stack in a second RAM: after the accept,
// each popped coordinate passes through stack read, frame read and test, each painted
// pixel then takes one stack write per neighbor, and a pop on the empty stack closes
// the fill. The single write port of each RAM sets this step order. Input is taken
// only while the sequencer is idle; a result waits in the output register and the
// next word is taken in the cycle that result drains.
module stack_flood_fill #(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 64,
	parameter int COLOR_BITS   = 4,
	parameter int STACK_DEPTH  = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sff_pkg::CMD_W-1:0]         cmd,
	input  logic [sff_pkg::COORD_IN_W-1:0]    x_coord,
	input  logic [sff_pkg::COORD_IN_W-1:0]    y_coord,
	input  logic [sff_pkg::COLOR_IN_W-1:0]    color_value,
	input  logic [sff_pkg::COLOR_IN_W-1:0]    border_color,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sff_pkg::COLOR_IN_W-1:0]    read_value,
	output logic [sff_pkg::COUNT_W-1:0]       filled_count,
	output logic                              overflow
);

	import sff_pkg::*;

	localparam int XW     = $clog2(FRAME_WIDTH);
	localparam int YW     = $clog2(FRAME_HEIGHT);
	localparam int PIX_AW = XW + YW;
	localparam int PIX_N  = 1 << PIX_AW;
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);

	localparam logic [XW-1:0] X_LAST = XW'(FRAME_WIDTH - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(FRAME_HEIGHT - 1);
	localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	// Sequencer state
	state_t              state_q;
	logic [PIX_AW-1:0]   clr_q;
	logic [SPW-1:0]      sp_q;
	logic [XW-1:0]       cur_x_q;
	logic [YW-1:0]       cur_y_q;
	nbr_t                nb_q;
	logic [COLOR_BITS-1:0] fill_q;
	logic [COLOR_BITS-1:0] border_q;
	logic [COUNT_W-1:0]  count_q;
	logic                dropped_q;

	// Output register
	logic                   out_valid_q;
	logic [COLOR_IN_W-1:0]  read_value_q;
	logic [COUNT_W-1:0]     filled_count_q;
	logic                   overflow_q;

	// RAM ports
	logic                  pix_wr_en;
	logic [PIX_AW-1:0]     pix_wr_addr;
	logic [COLOR_BITS-1:0] pix_wr_data;
	logic                  pix_rd_en;
	logic [PIX_AW-1:0]     pix_rd_addr;
	logic [COLOR_BITS-1:0] pix_rd_data;

	logic                  stk_wr_en;
	logic [SAW-1:0]        stk_wr_addr;
	logic [PIX_AW-1:0]     stk_wr_data;
	logic                  stk_rd_en;
	logic [SAW-1:0]        stk_rd_addr;
	logic [PIX_AW-1:0]     stk_rd_data;

	// Input decode
	logic                  accept;
	logic                  out_free;
	logic                  in_frame;
	logic [XW-1:0]         in_x;
	logic [YW-1:0]         in_y;
	logic [COLOR_BITS-1:0] in_color;
	logic [COLOR_BITS-1:0] in_border;

	// Fill datapath
	logic                  paint;
	logic                  nb_ok;
	logic [XW-1:0]         nb_x;
	logic [YW-1:0]         nb_y;
	logic                  sp_full;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;

	assign in_frame  = (32'(x_coord) < FRAME_WIDTH) && (32'(y_coord) < FRAME_HEIGHT);
	assign in_x      = XW'(x_coord);
	assign in_y      = YW'(y_coord);
	assign in_color  = COLOR_BITS'(color_value);
	assign in_border = COLOR_BITS'(border_color);

	// A popped pixel spreads unless it already holds the fill or border color
	assign paint   = (pix_rd_data != fill_q) && (pix_rd_data != border_q);
	assign sp_full = (sp_q == SP_FULL);

	// Neighbor of the current pixel for this push step, skipped at the frame edge
	always_comb begin
		nb_x  = cur_x_q;
		nb_y  = cur_y_q;
		nb_ok = 1'b0;
		case (nb_q)
			NB_DOWN: begin
				nb_y  = cur_y_q + YW'(1);
				nb_ok = (cur_y_q != Y_LAST);
			end
			NB_UP: begin
				nb_y  = cur_y_q - YW'(1);
				nb_ok = (cur_y_q != '0);
			end
			NB_RIGHT: begin
				nb_x  = cur_x_q + XW'(1);
				nb_ok = (cur_x_q != X_LAST);
			end
			NB_LEFT: begin
				nb_x  = cur_x_q - XW'(1);
				nb_ok = (cur_x_q != '0);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// Frame store port steering
	always_comb begin
		pix_wr_en   = 1'b0;
		pix_wr_addr = {in_y, in_x};
		pix_wr_data = in_color;
		pix_rd_en   = 1'b0;
		pix_rd_addr = {in_y, in_x};
		case (state_q)
			ST_CLEAR: begin
				pix_wr_en   = 1'b1;
				pix_wr_addr = clr_q;
				pix_wr_data = '0;
			end
			ST_IDLE: begin
				pix_wr_en = accept && (cmd == CMD_WRITE) && in_frame;
				pix_rd_en = accept && (cmd == CMD_READ) && in_frame;
			end
			ST_FETCH: begin
				pix_rd_en   = 1'b1;
				pix_rd_addr = stk_rd_data;
			end
			ST_TEST: begin
				pix_wr_en   = paint;
				pix_wr_addr = {cur_y_q, cur_x_q};
				pix_wr_data = fill_q;
			end
			default: begin
				pix_wr_en = 1'b0;
			end
		endcase
	end

	// Coordinate stack port steering
	always_comb begin
		stk_wr_en   = 1'b0;
		stk_wr_addr = '0;
		stk_wr_data = {in_y, in_x};
		stk_rd_en   = 1'b0;
		stk_rd_addr = SAW'(sp_q - SPW'(1));
		case (state_q)
			ST_IDLE: begin
				// seed goes in at the bottom of an empty stack
				stk_wr_en = accept && (cmd == CMD_FILL) && in_frame;
			end
			ST_POP: begin
				stk_rd_en = (sp_q != '0);
			end
			ST_PUSH: begin
				stk_wr_en   = nb_ok && !sp_full;
				stk_wr_addr = SAW'(sp_q);
				stk_wr_data = {nb_y, nb_x};
			end
			default: begin
				stk_wr_en = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			nb_q        <= NB_DOWN;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drain the output register when taken; an accepted word sets or clears it below
			if (out_valid_q && !out_stall && !accept) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PIX_AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if ((cmd == CMD_READ) && in_frame) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_READ;
						end else if ((cmd == CMD_FILL) && in_frame) begin
							out_valid_q <= 1'b0;
							sp_q        <= SPW'(1);
							count_q     <= '0;
							dropped_q   <= 1'b0;
							state_q     <= ST_POP;
						end else begin
							// write, off-frame word or unused code: result at once
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (paint) begin
						if (count_q != COUNT_SAT) begin
							count_q <= count_q + COUNT_W'(1);
						end
						nb_q    <= NB_DOWN;
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_PUSH: begin
					if (nb_ok) begin
						if (sp_full) begin
							dropped_q <= 1'b1;
						end else begin
							sp_q <= sp_q + SPW'(1);
						end
					end
					if (nb_q == NB_LEFT) begin
						state_q <= ST_POP;
					end else begin
						nb_q <= nbr_t'(nb_q + 2'd1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Fill context and current pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q   <= in_color;
			border_q <= in_border;
		end
		if (state_q == ST_FETCH) begin
			{cur_y_q, cur_x_q} <= stk_rd_data;
		end
	end

	// Result payload; loads only when the register is free
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					read_value_q   <= '0;
					filled_count_q <= '0;
					overflow_q     <= 1'b0;
				end
			end
			ST_READ: begin
				read_value_q <= COLOR_IN_W'(pix_rd_data);
			end
			ST_POP: begin
				if (sp_q == '0) begin
					filled_count_q <= count_q;
					overflow_q     <= dropped_q;
				end
			end
			default: begin
				read_value_q <= read_value_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign filled_count = filled_count_q;
	assign overflow     = overflow_q;

	sff_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (PIX_N)
	) u_frame (
		.clk     (clk),
		.wr_en   (pix_wr_en),
		.wr_addr (pix_wr_addr),
		.wr_data (pix_wr_data),
		.rd_en   (pix_rd_en),
		.rd_addr (pix_rd_addr),
		.rd_data (pix_rd_data)
	);

	sff_ram #(
		.WIDTH (PIX_AW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

endmodule

// ===== rtl/sff_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the frame store and the coordinate stack. No dependencies.
module sff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
